// File: design/tsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants for the three-stack shared-memory block.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int NUM_STACKS  = 3;
  localparam int MAX_SLOTS   = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int STORE_DEPTH = NUM_STACKS * MAX_SLOTS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int IDX_W  = ADDR_W + 1;
  localparam int FILL_W = $clog2(MAX_SLOTS + 1);
  localparam int SIDX_W = $clog2(NUM_STACKS);
  localparam int CFG_W  = 5;
  localparam int SEL_W  = 2;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(16);

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                   action;
    logic [SEL_W-1:0]             stack_select;
    logic signed [DATA_WIDTH-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [1:0]                   status;
    logic                         now_empty;
    logic                         now_full;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

endpackage

// File: design/tsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer: accept a request, execute it, load the result register.
// ----------------------------------------------------------------------------
module tsm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output tsm_pkg::cmd_t cmd
);
  import tsm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOAD} state_t;

  state_t state;
  logic   can_load;

  assign can_load    = (state == S_LOAD) && (!out_valid || !out_stall);
  assign cmd.capture = in_valid && !in_stall;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.load    = can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state    <= S_EXEC;
            in_stall <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (can_load) begin
            in_stall <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: design/tsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsm_dp
// Datapath: capacity register, fill counters, shared entry memory and
// result register.
// ----------------------------------------------------------------------------
module tsm_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  tsm_pkg::cmd_t          cmd,
  input  tsm_pkg::req_t          in_req,
  input  logic                   cfg_we,
  input  logic [tsm_pkg::CFG_W-1:0] cfg_wdata,
  output tsm_pkg::rsp_t          out_rsp
);
  import tsm_pkg::*;

  logic [CFG_W-1:0]             slots;
  logic [FILL_W-1:0]            stack_fill [NUM_STACKS];
  logic signed [DATA_WIDTH-1:0] mem [STORE_DEPTH];

  req_t                         req;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic                         rd_ok;
  logic [1:0]                   res_status;
  logic                         res_empty;
  logic                         res_full;

  logic [FILL_W-1:0] cap;
  logic              sel_ok;
  logic [SIDX_W-1:0] sel_ix;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [IDX_W-1:0]  base;
  logic [IDX_W-1:0]  idx_push;
  logic [IDX_W-1:0]  idx_pop;
  logic              push_ok;
  logic              read_ok;
  logic [1:0]        status_next;

  always_comb begin
    if (slots == '0) begin
      cap = FILL_W'(1);
    end else if (32'(slots) > MAX_SLOTS) begin
      cap = FILL_W'(MAX_SLOTS);
    end else begin
      cap = FILL_W'(slots);
    end
  end

  assign sel_ok   = (32'(req.stack_select) < NUM_STACKS);
  assign sel_ix   = SIDX_W'(req.stack_select);
  assign base     = IDX_W'(sel_ix) * IDX_W'(cap);
  assign idx_push = base + IDX_W'(fill);
  assign idx_pop  = idx_push - IDX_W'(1);

  always_comb begin
    fill        = '0;
    fill_next   = '0;
    push_ok     = 1'b0;
    read_ok     = 1'b0;
    status_next = ST_DONE;
    if (sel_ok) begin
      fill      = stack_fill[sel_ix];
      fill_next = fill;
      case (req.action)
        ACT_PUSH: begin
          if (fill >= cap) begin
            status_next = ST_FULL;
          end else begin
            push_ok   = 1'b1;
            fill_next = fill + FILL_W'(1);
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (fill == '0) begin
            status_next = ST_EMPTY;
          end else begin
            read_ok = 1'b1;
            if (req.action == ACT_POP) begin
              fill_next = fill - FILL_W'(1);
            end
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end else begin
      case (req.action)
        ACT_PUSH:          status_next = ST_FULL;
        ACT_POP, ACT_PEEK: status_next = ST_EMPTY;
        default:           status_next = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= SLOTS_RESET;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        slots <= cfg_wdata;
      end
      if (cmd.exec && sel_ok) begin
        stack_fill[sel_ix] <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_req;
    end
    if (cmd.exec) begin
      rd_ok      <= read_ok;
      res_status <= status_next;
      res_empty  <= !sel_ok || (fill_next == '0);
      res_full   <= !sel_ok || (fill_next >= cap);
    end
    if (cmd.load) begin
      out_rsp.read_value <= rd_ok ? rd_data : '0;
      out_rsp.status     <= res_status;
      out_rsp.now_empty  <= res_empty;
      out_rsp.now_full   <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok && (32'(idx_push) < STORE_DEPTH)) begin
      mem[idx_push[ADDR_W-1:0]] <= req.push_value;
    end
    if (cmd.exec && read_ok && (32'(idx_pop) < STORE_DEPTH)) begin
      rd_data <= mem[idx_pop[ADDR_W-1:0]];
    end
  end

endmodule

// File: design/three_stacks_in_one_memory.sv
`timescale 1ns / 1ps
// An accepted request passes through the execute and load states before result valid;
//   the load waits while a held result is stalled. The sequencer handles one request
//   at a time (execute with one memory access, then load the result register).
// A result waiting on out_stall does not block acceptance of the next request.
// Reset (synchronous, active high) empties all stacks and sets capacity to 16.
// ----------------------------------------------------------------------------
// three_stacks_in_one_memory
// Three fixed-partition LIFO stacks sharing one entry memory.
// ----------------------------------------------------------------------------
module three_stacks_in_one_memory (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tsm_pkg::req_t             in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tsm_pkg::rsp_t             out_rsp,
  input  logic                      cfg_we,
  input  logic [tsm_pkg::CFG_W-1:0] cfg_wdata
);
  import tsm_pkg::*;

  cmd_t cmd;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_rsp   (out_rsp)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.status == ST_FULL) |-> out_rsp.now_full)
    else $error("full refusal without full flag");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.status == ST_EMPTY) |->
      (out_rsp.now_empty && out_rsp.read_value == '0))
    else $error("empty refusal with data or without empty flag");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a request in flight");

endmodule
